// ===== design/ucecm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucecm_pkg
// Shared codes and descriptor constants for the CDC ECM configuration
// descriptor parser.
// ----------------------------------------------------------------------------
package ucecm_pkg;

    // verdict codes
    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_NOT_CONFIG = 2'd1;
    localparam logic [1:0] STATUS_SHORT_DESC = 2'd2;
    localparam logic [1:0] STATUS_MISSING    = 2'd3;

    // internal error codes share the verdict encoding
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NOT_CONFIG = 2'd1;
    localparam logic [1:0] ERR_SHORT_DESC = 2'd2;

    // descriptor constants
    localparam logic [7:0]  DT_CONFIG        = 8'h02;
    localparam logic [7:0]  DT_INTERFACE     = 8'h04;
    localparam logic [7:0]  DT_ENDPOINT      = 8'h05;
    localparam logic [7:0]  DT_CS_INTERFACE  = 8'h24;
    localparam logic [7:0]  SUBTYPE_ETHERNET = 8'h0F;
    localparam logic [7:0]  CLASS_CDC_CTRL   = 8'h02;
    localparam logic [7:0]  CLASS_CDC_DATA   = 8'h0A;
    localparam logic [1:0]  XFER_BULK        = 2'b10;
    localparam logic [7:0]  MIN_DESC_LEN     = 8'd2;
    localparam logic [16:0] FIRST_SUB_OFFSET = 17'd9;
    localparam logic [15:0] POS_SATURATED    = 16'hFFFF;

    localparam logic [15:0] POS_TYPE     = 16'd1;
    localparam logic [15:0] POS_LEN_LOW  = 16'd2;
    localparam logic [15:0] POS_LEN_HIGH = 16'd3;

endpackage

// ===== design/usb_cdc_ecm_config_descriptor_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_cdc_ecm_config_descriptor_parser
// Streams a USB configuration descriptor byte by byte and reports the CDC
// ECM bulk endpoints and MAC string index on the final byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one descriptor byte per transaction,
//   last_byte set on the final byte of the descriptor.
//   Output channel (out_valid/out_ready): one verdict per descriptor, carrying
//   status, in_endpoint_id, out_endpoint_id and mac_string_index.
//   Throughput: one byte per cycle while in_ready is high; all parse state is updated by a single
//   level of compare/add logic straight from the accepted byte.
//   Output: the verdict is registered from the final byte and sits in the
//   output register from the cycle after that byte is accepted.
//   Stall: in_ready drops only while a verdict sits in the output register
//   and out_ready is low; bytes without last_byte keep flowing otherwise
//   since they produce no output.
//   Reset: clears all parse state and the output valid; after each verdict
//   the parse state returns to its reset value so the next byte begins a
//   new descriptor.
// ----------------------------------------------------------------------------
module usb_cdc_ecm_config_descriptor_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [4:0] in_endpoint_id,
    output logic [4:0] out_endpoint_id,
    output logic [7:0] mac_string_index
);

    logic [15:0] pos_reg,        pos_next;
    logic [15:0] total_len_reg,  total_len_next;
    logic [16:0] desc_start_reg, desc_start_next;
    logic [1:0]  found_reg,      found_next;
    logic [1:0]  err_reg,        err_next;
    logic [7:0]  bulk_in_reg,    bulk_in_next;
    logic [7:0]  bulk_out_reg,   bulk_out_next;
    logic [7:0]  mac_reg,        mac_next;
    logic [7:0]  win_reg [4];
    logic [7:0]  win_next [4];
    logic [4:0]  mask_reg,       mask_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg,     status_next;
    logic [4:0]  in_id_reg,      in_id_next;
    logic [4:0]  out_id_reg,     out_id_next;
    logic [7:0]  mac_out_reg,    mac_out_next;

    logic        accept;
    logic        active;
    logic        walk;
    logic        start_hit;
    logic [7:0]  w1, w2, w4;
    logic        m3, m5;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign w1 = win_reg[0];
    assign w2 = win_reg[1];
    assign w4 = win_reg[3];
    assign m3 = mask_reg[2];
    assign m5 = mask_reg[4];

    always_comb
    begin
        pos_next        = pos_reg;
        total_len_next  = total_len_reg;
        desc_start_next = desc_start_reg;
        found_next      = found_reg;
        err_next        = err_reg;
        bulk_in_next    = bulk_in_reg;
        bulk_out_next   = bulk_out_reg;
        mac_next        = mac_reg;
        win_next        = win_reg;
        mask_next       = mask_reg;
        start_hit       = 1'b0;

        active = (pos_reg != ucecm_pkg::POS_SATURATED);

        if (active)
        begin
            if (pos_reg == ucecm_pkg::POS_TYPE && data_byte != ucecm_pkg::DT_CONFIG)
            begin
                err_next = ucecm_pkg::ERR_NOT_CONFIG;
            end
            if (pos_reg == ucecm_pkg::POS_LEN_LOW)
            begin
                total_len_next = {total_len_reg[15:8], data_byte};
            end
            if (pos_reg == ucecm_pkg::POS_LEN_HIGH)
            begin
                total_len_next = {data_byte, total_len_reg[7:0]};
            end
            pos_next = pos_reg + 16'd1;
        end

        walk = active && (err_next != ucecm_pkg::ERR_NOT_CONFIG);

        if (walk)
        begin
            // a sub-descriptor starts here if it begins 3 or more bytes before the end
            start_hit = ({1'b0, pos_reg} == desc_start_reg) &&
                        (err_next == ucecm_pkg::ERR_NONE) &&
                        (({1'b0, desc_start_reg} + 18'd2) < {2'b00, total_len_next});
            if (start_hit)
            begin
                if (data_byte < ucecm_pkg::MIN_DESC_LEN)
                begin
                    err_next = ucecm_pkg::ERR_SHORT_DESC;
                end
                else
                begin
                    desc_start_next = desc_start_reg + {9'd0, data_byte};
                end
            end

            // interface class byte first, so a class check in this cycle sees it
            if (m5 && w4 == ucecm_pkg::DT_INTERFACE)
            begin
                if (data_byte == ucecm_pkg::CLASS_CDC_CTRL)
                begin
                    found_next[0] = 1'b1;
                end
                else if (data_byte == ucecm_pkg::CLASS_CDC_DATA)
                begin
                    found_next[1] = 1'b1;
                end
            end

            if (m3)
            begin
                if (w2 == ucecm_pkg::DT_CS_INTERFACE)
                begin
                    if (w1 == ucecm_pkg::SUBTYPE_ETHERNET && found_next[0])
                    begin
                        mac_next = data_byte;
                    end
                end
                else if (w2 == ucecm_pkg::DT_ENDPOINT)
                begin
                    if (data_byte[1:0] == ucecm_pkg::XFER_BULK)
                    begin
                        if (w1[7])
                        begin
                            bulk_in_next = w1;
                        end
                        else
                        begin
                            bulk_out_next = w1;
                        end
                    end
                end
            end

            win_next[0] = data_byte;
            win_next[1] = win_reg[0];
            win_next[2] = win_reg[1];
            win_next[3] = win_reg[2];
            mask_next   = {mask_reg[3:0], start_hit};
        end
    end

    // verdict from the state after this byte
    always_comb
    begin
        in_id_next   = 5'd0;
        out_id_next  = 5'd0;
        mac_out_next = mac_next;
        if (pos_next < 16'd2 || err_next == ucecm_pkg::ERR_NOT_CONFIG)
        begin
            status_next  = ucecm_pkg::STATUS_NOT_CONFIG;
            mac_out_next = 8'd0;
        end
        else if (err_next == ucecm_pkg::ERR_SHORT_DESC)
        begin
            status_next = ucecm_pkg::STATUS_SHORT_DESC;
        end
        else if (found_next != 2'b11 || bulk_in_next == 8'd0 || bulk_out_next == 8'd0)
        begin
            status_next = ucecm_pkg::STATUS_MISSING;
        end
        else
        begin
            status_next = ucecm_pkg::STATUS_FOUND;
            in_id_next  = {bulk_in_next[3:0], 1'b1};
            out_id_next = {bulk_out_next[3:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            total_len_reg  <= '0;
            desc_start_reg <= ucecm_pkg::FIRST_SUB_OFFSET;
            found_reg      <= '0;
            err_reg        <= ucecm_pkg::ERR_NONE;
            bulk_in_reg    <= '0;
            bulk_out_reg   <= '0;
            mac_reg        <= '0;
            mask_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // verdict issued: start a fresh descriptor
                pos_reg        <= '0;
                total_len_reg  <= '0;
                desc_start_reg <= ucecm_pkg::FIRST_SUB_OFFSET;
                found_reg      <= '0;
                err_reg        <= ucecm_pkg::ERR_NONE;
                bulk_in_reg    <= '0;
                bulk_out_reg   <= '0;
                mac_reg        <= '0;
                mask_reg       <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg        <= pos_next;
                total_len_reg  <= total_len_next;
                desc_start_reg <= desc_start_next;
                found_reg      <= found_next;
                err_reg        <= err_next;
                bulk_in_reg    <= bulk_in_next;
                bulk_out_reg   <= bulk_out_next;
                mac_reg        <= mac_next;
                mask_reg       <= mask_next;
                win_reg        <= win_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            status_reg  <= status_next;
            in_id_reg   <= in_id_next;
            out_id_reg  <= out_id_next;
            mac_out_reg <= mac_out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign in_endpoint_id   = in_id_reg;
    assign out_endpoint_id  = out_id_reg;
    assign mac_string_index = mac_out_reg;

`ifndef SYNTHESIS
    a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> out_valid)
        else $error("no verdict after final byte");

    a_ids_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ucecm_pkg::STATUS_FOUND |->
            in_endpoint_id == 5'd0 && out_endpoint_id == 5'd0)
        else $error("endpoint id reported without a found verdict");

    a_id_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ucecm_pkg::STATUS_FOUND |->
            in_endpoint_id[0] && !out_endpoint_id[0])
        else $error("endpoint id direction bit wrong");

    a_no_mac_on_bad_config: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ucecm_pkg::STATUS_NOT_CONFIG |-> mac_string_index == 8'd0)
        else $error("mac index reported for a non-config descriptor");

    a_position_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_byte |=> pos_reg != 16'd0)
        else $error("byte position failed to advance");
`endif

endmodule

// ===== test/usb_cdc_ecm_config_descriptor_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_cdc_ecm_config_descriptor_parser_test
// Streams CDC ECM configuration descriptors, mostly well formed with random
// content plus broken and noise streams, into the parser. A scoreboard walks
// each accepted byte through its own parser and compares every verdict
// field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0] status;
    logic [4:0] in_id;
    logic [4:0] out_id;
    logic [7:0] mac;
} ecm_verdict_t;

class ecm_verdict_scoreboard;
    ecm_verdict_t verdicts_due[$];
    int mismatches;

    logic [15:0] byte_pos;
    logic [15:0] total_len;
    int unsigned next_start;
    logic [1:0]  iface_seen;    // bit 0 control class, bit 1 data class
    logic [1:0]  err;
    logic [7:0]  in_addr;
    logic [7:0]  out_addr;
    logic [7:0]  mac_idx;
    logic [7:0]  recent [6];    // last six bytes, newest at 0
    logic [5:0]  starts;        // walked descriptor starts inside recent

    function new();
        mismatches = 0;
        clear();
    endfunction

    function void clear();
        byte_pos   = '0;
        total_len  = '0;
        next_start = ucecm_pkg::FIRST_SUB_OFFSET;
        iface_seen = '0;
        err        = ucecm_pkg::ERR_NONE;
        in_addr    = '0;
        out_addr   = '0;
        mac_idx    = '0;
        starts     = '0;
        for (int k = 0; k < 6; k++)
            recent[k] = '0;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    function void walk(logic [7:0] b);
        for (int k = 5; k > 0; k--)
            recent[k] = recent[k - 1];
        recent[0] = b;
        starts = {starts[4:0], 1'b0};

        if (byte_pos == next_start && err == ucecm_pkg::ERR_NONE &&
            next_start + 2 < total_len)
        begin
            starts[0] = 1'b1;
            if (b < ucecm_pkg::MIN_DESC_LEN)
                err = ucecm_pkg::ERR_SHORT_DESC;
            else
                next_start += b;
        end

        // oldest start first: an interface decided now counts for a class check
        if (starts[5] && recent[4] == ucecm_pkg::DT_INTERFACE)
        begin
            if (recent[0] == ucecm_pkg::CLASS_CDC_CTRL)
                iface_seen[0] = 1'b1;
            else if (recent[0] == ucecm_pkg::CLASS_CDC_DATA)
                iface_seen[1] = 1'b1;
        end
        if (starts[3])
        begin
            if (recent[2] == ucecm_pkg::DT_CS_INTERFACE)
            begin
                if (recent[1] == ucecm_pkg::SUBTYPE_ETHERNET && iface_seen[0])
                    mac_idx = recent[0];
            end
            else if (recent[2] == ucecm_pkg::DT_ENDPOINT &&
                     recent[0][1:0] == ucecm_pkg::XFER_BULK)
            begin
                if (recent[1][7])
                    in_addr = recent[1];
                else
                    out_addr = recent[1];
            end
        end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        ecm_verdict_t v;
        if (byte_pos != ucecm_pkg::POS_SATURATED)
        begin
            if (byte_pos == ucecm_pkg::POS_TYPE)
            begin
                if (b != ucecm_pkg::DT_CONFIG)
                    err = ucecm_pkg::ERR_NOT_CONFIG;
            end
            else if (byte_pos == ucecm_pkg::POS_LEN_LOW)
                total_len[7:0] = b;
            else if (byte_pos == ucecm_pkg::POS_LEN_HIGH)
                total_len[15:8] = b;
            if (err != ucecm_pkg::ERR_NOT_CONFIG)
                walk(b);
            byte_pos = byte_pos + 16'd1;
        end
        if (!last)
            return;

        v = '0;
        if (byte_pos < 2 || err == ucecm_pkg::ERR_NOT_CONFIG)
            v.status = ucecm_pkg::STATUS_NOT_CONFIG;
        else if (err == ucecm_pkg::ERR_SHORT_DESC)
        begin
            v.status = ucecm_pkg::STATUS_SHORT_DESC;
            v.mac = mac_idx;
        end
        else if (iface_seen != 2'b11 || in_addr == 0 || out_addr == 0)
        begin
            v.status = ucecm_pkg::STATUS_MISSING;
            v.mac = mac_idx;
        end
        else
        begin
            v.status = ucecm_pkg::STATUS_FOUND;
            v.in_id = {in_addr[3:0], 1'b1};
            v.out_id = {out_addr[3:0], 1'b0};
            v.mac = mac_idx;
        end
        verdicts_due.push_back(v);
        clear();
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_verdict(logic [1:0] st, logic [4:0] in_id, logic [4:0] out_id,
                                logic [7:0] mac);
        ecm_verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            $display("%0t: verdict expected none, got status=%0d in=%0d out=%0d mac=%0d",
                     $time, st, in_id, out_id, mac);
            mismatches++;
            return;
        end
        want = verdicts_due.pop_front();
        compare_field("status", want.status, st);
        compare_field("in_endpoint_id", want.in_id, in_id);
        compare_field("out_endpoint_id", want.out_id, out_id);
        compare_field("mac_string_index", want.mac, mac);
    endfunction
endclass

module usb_cdc_ecm_config_descriptor_parser_test;

    localparam int ITEM_TARGET  = 1450;
    localparam int QUIET_LIMIT  = 3000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [4:0] in_endpoint_id;
    logic [4:0] out_endpoint_id;
    logic [7:0] mac_string_index;

    ecm_verdict_scoreboard sb;
    logic [7:0] frame[$];
    int in_idle_pct;
    int out_idle_pct;
    int bytes_sent;
    int frames_sent;
    int quiet_cycles;

    usb_cdc_ecm_config_descriptor_parser dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .in_endpoint_id   (in_endpoint_id),
        .out_endpoint_id  (out_endpoint_id),
        .mac_string_index (mac_string_index)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_verdict(status, in_endpoint_id, out_endpoint_id, mac_string_index);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void put(logic [7:0] b);
        frame.push_back(b);
    endfunction

    function automatic void put_interface(logic [7:0] cls);
        put(8'd9);
        put(ucecm_pkg::DT_INTERFACE);
        put(rnd_byte());
        put(rnd_byte());
        put(rnd_byte());
        put(cls);
        put(rnd_byte());
        put(rnd_byte());
        put(rnd_byte());
    endfunction

    function automatic void put_endpoint(logic [7:0] addr, logic [1:0] xfer);
        put(8'd7);
        put(ucecm_pkg::DT_ENDPOINT);
        put(addr);
        put({6'($urandom_range(63)), xfer});
        put(rnd_byte());
        put(rnd_byte());
        put(rnd_byte());
    endfunction

    // class-specific descriptor; the byte after the subtype is random
    function automatic void put_class_desc(int len, logic [7:0] subtype);
        put(8'(len));
        put(ucecm_pkg::DT_CS_INTERFACE);
        put(subtype);
        for (int k = 3; k < len; k++)
            put(rnd_byte());
    endfunction

    // odd piece: short lengths make fields overlap, length under 2 stops the walk
    function automatic void put_odd_piece();
        int len;
        logic [7:0] kind;
        len = chance(6) ? $urandom_range(1) : $urandom_range(2, 12);
        case ($urandom_range(3))
            0: kind = ucecm_pkg::DT_INTERFACE;
            1: kind = ucecm_pkg::DT_ENDPOINT;
            2: kind = ucecm_pkg::DT_CS_INTERFACE;
            default: kind = rnd_byte();
        endcase
        put(8'(len));
        put(kind);
        for (int k = 2; k < len; k++)
        begin
            case ($urandom_range(5))
                0: put(ucecm_pkg::SUBTYPE_ETHERNET);
                1: put({6'($urandom_range(63)), ucecm_pkg::XFER_BULK});
                2: put(chance(50) ? ucecm_pkg::CLASS_CDC_CTRL : ucecm_pkg::CLASS_CDC_DATA);
                default: put(rnd_byte());
            endcase
        end
    endfunction

    function automatic void build_descriptor();
        bit eth_first;
        logic [7:0] out_addr;
        int cut;
        frame.delete();

        if (chance(6))
        begin
            repeat ($urandom_range(1, 24))
                put(rnd_byte());
            return;
        end

        put(8'd9);
        put(ucecm_pkg::DT_CONFIG);
        put(8'h00);
        put(8'h00);
        repeat (5)
            put(rnd_byte());

        eth_first = chance(10);
        if (eth_first && chance(90))
            put_class_desc(13, ucecm_pkg::SUBTYPE_ETHERNET);
        if (chance(92))
            put_interface(chance(90) ? ucecm_pkg::CLASS_CDC_CTRL : rnd_byte());
        if (chance(15)) put_odd_piece();
        if (chance(85))
            put_class_desc(5, 8'h00);
        if (chance(85))
            put_class_desc(5, 8'h06);
        if (!eth_first && chance(90))
            put_class_desc(13, ucecm_pkg::SUBTYPE_ETHERNET);
        if (chance(15)) put_odd_piece();
        if (chance(80))
            put_endpoint({1'b1, 7'($urandom_range(127))}, 2'b11);
        if (chance(92))
            put_interface(chance(90) ? ucecm_pkg::CLASS_CDC_DATA : rnd_byte());
        if (chance(15)) put_odd_piece();
        if (chance(92))
            put_endpoint({1'b1, 7'($urandom_range(127))},
                         chance(90) ? ucecm_pkg::XFER_BULK : 2'($urandom_range(3)));
        if (chance(15)) put_odd_piece();
        out_addr = chance(10) ? 8'h00 : {1'b0, 7'($urandom_range(127))};
        if (chance(92))
            put_endpoint(out_addr, chance(90) ? ucecm_pkg::XFER_BULK : 2'($urandom_range(3)));
        if (chance(10)) put_odd_piece();

        if (chance(85))
        begin
            frame[2] = 8'(frame.size());
            frame[3] = 8'(frame.size() >> 8);
        end
        else if (chance(80))
            frame[2] = 8'($urandom_range(frame.size() + 20));
        else
        begin
            frame[2] = 8'hFF;
            frame[3] = 8'hFF;
        end

        if (chance(5))
            frame[1] = rnd_byte();
        if (chance(5))
            frame[$urandom_range(frame.size() - 1)] = rnd_byte();
        if (chance(8))
        begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
        else if (chance(8))
            repeat ($urandom_range(1, 12))
                put(rnd_byte());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame.size();
        for (int i = 0; i < n; i++)
            send_byte(frame[i], i == n - 1);
        frames_sent++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        out_ready = 1'b0;
        in_idle_pct = 13;
        out_idle_pct = 80;
        bytes_sent = 0;
        frames_sent = 0;
        quiet_cycles = 0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream too short to carry the type byte
        frame.delete();
        put(8'hFF);
        send_frame();

        // wrong descriptor type
        frame.delete();
        put(8'h00);
        put(8'h07);
        put(8'h00);
        send_frame();

        // first sub-descriptor with length zero, stream ends inside it
        frame.delete();
        put(8'h09);
        put(ucecm_pkg::DT_CONFIG);
        put(8'h20);
        put(8'h00);
        put(8'h01);
        put(8'h01);
        put(8'h00);
        put(8'h80);
        put(8'hFA);
        put(8'h00);
        put(ucecm_pkg::DT_INTERFACE);
        send_frame();

        // header only: nothing found
        frame.delete();
        put(8'h09);
        put(ucecm_pkg::DT_CONFIG);
        put(8'h09);
        put(8'h00);
        repeat (5)
            put(8'hFF);
        send_frame();

        for (int phase = 0; phase < 3; phase++)
        begin
            in_idle_pct  = (phase == 0) ? 13 : (phase == 1) ? 80 : 0;
            out_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 13 : 0;
            while (bytes_sent < ITEM_TARGET * (phase + 1) / 3)
            begin
                build_descriptor();
                send_frame();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
